// ===== hdl/rscp_pkg.sv =====
// ----------------------------------------------------------------------------
// rscp_pkg: shared types and constants of the resizing stack
// Holds reset defaults, field widths, status and register codes, and the
// command bundle that the controller hands to the datapath.
// ----------------------------------------------------------------------------
package rscp_pkg;

  localparam int MemDepthDef    = 1024;
  localparam int DataWidthDef   = 32;
  localparam int MinCapacityDef = 10;

  localparam int FracW    = 8;   // fractional bits of thresholds and ratios
  localparam int CfgW     = 16;  // width of one configuration register
  localparam int CfgIdxW  = 2;   // width of the register index
  localparam int StatW    = 2;
  localparam int EvtW     = 32;  // width of the resize event counter

  localparam logic [CfgW-1:0] FullThrRst   = 16'd256;
  localparam logic [CfgW-1:0] EmptyThrRst  = 16'd38;
  localparam logic [CfgW-1:0] GrowRatioRst = 16'd512;
  localparam logic [CfgW-1:0] ShrkRatioRst = 16'd128;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FULL_THR   = 2'd0,
    REG_EMPTY_THR  = 2'd1,
    REG_GROW_RATIO = 2'd2,
    REG_SHRK_RATIO = 2'd3
  } cfg_idx_e;

  // Controller to datapath command bundle
  typedef struct packed {
    logic capture;   // latch the accepted operation
    logic mul;       // form threshold and ratio products
    logic upd;       // resize decision, stack update, memory access
    logic load;      // move the result into the output register
  } cmd_t;

endpackage

// ===== hdl/rscp_ctrl.sv =====
// ----------------------------------------------------------------------------
// rscp_ctrl: operation sequencer of the resizing stack
// Steps each accepted operation through multiply, update and result load,
// and owns the input stall and the output valid.
// ----------------------------------------------------------------------------
module rscp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rscp_pkg::cmd_t cmd_o
);
  import rscp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_UPD,
    S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // Output register can take a new result when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.capture = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul     = (state_q == S_MUL);
    cmd_o.upd     = (state_q == S_UPD);
    cmd_o.load    = (state_q == S_OUT) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // A new load wins over the drain of the previous result
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_UPD;
        S_UPD: state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/rscp_dpath.sv =====
// ----------------------------------------------------------------------------
// rscp_dpath: stack datapath with capacity policy
// Holds configuration, item memory, count, capacity, statistics and the
// output register; multiplies once per operation and updates on command.
// ----------------------------------------------------------------------------
module rscp_dpath #(
  parameter int MEM_DEPTH    = rscp_pkg::MemDepthDef,
  parameter int DATA_WIDTH   = rscp_pkg::DataWidthDef,
  parameter int MIN_CAPACITY = rscp_pkg::MinCapacityDef,
  localparam int CntW        = $clog2(MEM_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rscp_pkg::cmd_t               cmd_i,
  input  logic                         cfg_we_i,
  input  logic [rscp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rscp_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         func_i,
  input  logic [DATA_WIDTH-1:0]        push_value_i,
  output logic [DATA_WIDTH-1:0]        popped_value_o,
  output logic [rscp_pkg::StatW-1:0]   status_o,
  output logic [CntW-1:0]              item_count_o,
  output logic [CntW-1:0]              capacity_o,
  output logic [rscp_pkg::EvtW-1:0]    resize_total_o,
  output logic [CntW-1:0]              peak_capacity_o
);
  import rscp_pkg::*;

  localparam int AddrW = $clog2(MEM_DEPTH);
  localparam int ProdW = CntW + CfgW;

  localparam logic [CntW-1:0]  DepthCnt  = CntW'(MEM_DEPTH);
  localparam logic [CntW-1:0]  MinCap    = CntW'(MIN_CAPACITY);
  localparam logic [ProdW-1:0] DepthProd = ProdW'(MEM_DEPTH);
  localparam logic [EvtW-1:0]  EvtMax    = '1;

  logic [CfgW-1:0] full_thr_q, empty_thr_q, grow_ratio_q, shrk_ratio_q;

  logic                  func_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [CntW-1:0]       cnt_q, cap_q, peak_q;
  logic [EvtW-1:0]       evt_q;
  logic [ProdW-1:0]      thr_prod_q, scale_prod_q;
  status_e               stat_q;

  logic [DATA_WIDTH-1:0] mem_q [MEM_DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;

  logic [CfgW-1:0]  sel_thr, sel_ratio;
  logic [ProdW-1:0] cnt_frac, scaled_raw, scaled_full;
  logic [CntW-1:0]  scaled;
  logic             grow_hit, shrink_hit, resize;
  logic             push_ok, pop_ok;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [CntW-1:0]  cnt_dec;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_thr_q   <= FullThrRst;
      empty_thr_q  <= EmptyThrRst;
      grow_ratio_q <= GrowRatioRst;
      shrk_ratio_q <= ShrkRatioRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        REG_FULL_THR:   full_thr_q   <= cfg_data_i;
        REG_EMPTY_THR:  empty_thr_q  <= cfg_data_i;
        REG_GROW_RATIO: grow_ratio_q <= cfg_data_i;
        REG_SHRK_RATIO: shrk_ratio_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Products and resize decision
  always_comb begin
    sel_thr     = (func_q == FUNC_PUSH) ? full_thr_q : empty_thr_q;
    sel_ratio   = (func_q == FUNC_PUSH) ? grow_ratio_q : shrk_ratio_q;
    cnt_frac    = ProdW'({cnt_q, {FracW{1'b0}}});
    grow_hit    = (cnt_frac >= thr_prod_q);
    shrink_hit  = (cnt_frac < thr_prod_q) && (cap_q > MinCap);
    resize      = (func_q == FUNC_PUSH) ? grow_hit : shrink_hit;
    scaled_raw  = scale_prod_q >> FracW;
    scaled_full = (scaled_raw > DepthProd) ? DepthProd : scaled_raw;
    scaled      = scaled_full[CntW-1:0];
    push_ok     = (func_q == FUNC_PUSH) && (cnt_q < DepthCnt);
    pop_ok      = (func_q == FUNC_POP) && (cnt_q != '0);
    cnt_dec     = cnt_q - CntW'(1);
    wr_addr     = cnt_q[AddrW-1:0];
    rd_addr     = cnt_dec[AddrW-1:0];
  end

  // Operation latch and products
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      value_q <= push_value_i;
    end
    if (cmd_i.mul) begin
      thr_prod_q   <= ProdW'(sel_thr) * ProdW'(cap_q);
      scale_prod_q <= ProdW'(sel_ratio) * ProdW'(cap_q);
    end
  end

  // Stack state and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      cap_q  <= MinCap;
      peak_q <= '0;
      evt_q  <= '0;
      stat_q <= ST_OK;
    end else if (cmd_i.upd) begin
      if (resize) begin
        cap_q <= scaled;
        if (evt_q != EvtMax) begin
          evt_q <= evt_q + EvtW'(1);
        end
        if ((func_q == FUNC_PUSH) && (scaled > peak_q)) begin
          peak_q <= scaled;
        end
      end
      if (push_ok) begin
        cnt_q  <= cnt_q + CntW'(1);
        stat_q <= ST_OK;
      end else if (pop_ok) begin
        cnt_q  <= cnt_dec;
        stat_q <= ST_OK;
      end else if (func_q == FUNC_PUSH) begin
        stat_q <= ST_FULL;
      end else begin
        stat_q <= ST_EMPTY;
      end
    end
  end

  // Item memory, at most one write and one registered read per update
  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      if (push_ok) begin
        mem_q[wr_addr] <= value_q;
      end
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      popped_value_o  <= ((func_q == FUNC_POP) && (stat_q == ST_OK)) ? rd_data_q : '0;
      status_o        <= stat_q;
      item_count_o    <= cnt_q;
      capacity_o      <= cap_q;
      resize_total_o  <= evt_q;
      peak_capacity_o <= peak_q;
    end
  end

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("item count above memory depth");

  a_cap_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q <= DepthCnt) || (cap_q == MinCap))
    else $error("capacity above memory depth");

  a_empty_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && (func_q == FUNC_POP) && (cnt_q == '0) |=> stat_q == ST_EMPTY)
    else $error("pop on empty stack not flagged");

  a_full_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && (func_q == FUNC_PUSH) && (cnt_q == DepthCnt) |=>
      (stat_q == ST_FULL) && (cnt_q == DepthCnt))
    else $error("push into full memory not flagged");

endmodule

// ===== hdl/resizing_stack_capacity_policy.sv =====
// ----------------------------------------------------------------------------
// resizing_stack_capacity_policy: stack with grow and shrink capacity policy
// Push and pop into a fixed memory while tracking a logical capacity,
// resize events and peak capacity.
// ----------------------------------------------------------------------------
// Each operation (func 0 push, func 1 pop) goes from transfer in to
// result ready through these steps in order: accept, the threshold and
// ratio multipliers, the resize decision with the item memory access, and
// the load of the output register. The input stalls during that sequence,
// so a new operation is taken only after the last one has loaded its
// result, and the sequence holds in its last step only while the output
// register is still full and stalled. Before a push the capacity grows by
// grow_ratio when count*256 >= full_threshold*capacity; before a pop it
// shrinks by shrink_ratio when count*256 < empty_threshold*capacity and
// the capacity is above MIN_CAPACITY. Thresholds and ratios carry 8
// fractional bits, products are truncated and clamped to MEM_DEPTH, and
// every resize step counts as an event even when the value is unchanged.
// A push into a full memory reports status 2 and stores nothing; a pop on
// an empty stack reports status 1 and a zero value. Configuration writes
// are always ready and should be issued only while no operation is in
// flight. The item memory needs no clearing pass: only entries below the
// count ever reach the popped value.
// ----------------------------------------------------------------------------
module resizing_stack_capacity_policy #(
  parameter int MEM_DEPTH    = rscp_pkg::MemDepthDef,
  parameter int DATA_WIDTH   = rscp_pkg::DataWidthDef,
  parameter int MIN_CAPACITY = rscp_pkg::MinCapacityDef,
  localparam int CntW        = $clog2(MEM_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // operation channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [DATA_WIDTH-1:0]        push_value_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [DATA_WIDTH-1:0]        popped_value_o,
  output logic [rscp_pkg::StatW-1:0]   status_o,
  output logic [CntW-1:0]              item_count_o,
  output logic [CntW-1:0]              capacity_o,
  output logic [rscp_pkg::EvtW-1:0]    resize_total_o,
  output logic [CntW-1:0]              peak_capacity_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rscp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rscp_pkg::CfgW-1:0]    cfg_data_i
);
  import rscp_pkg::*;

  cmd_t cmd;

  // Register writes go straight into the registers, so never hold off the writer
  assign cfg_ready_o = 1'b1;

  rscp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rscp_dpath #(
    .MEM_DEPTH    (MEM_DEPTH),
    .DATA_WIDTH   (DATA_WIDTH),
    .MIN_CAPACITY (MIN_CAPACITY)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .push_value_i    (push_value_i),
    .popped_value_o  (popped_value_o),
    .status_o        (status_o),
    .item_count_o    (item_count_o),
    .capacity_o      (capacity_o),
    .resize_total_o  (resize_total_o),
    .peak_capacity_o (peak_capacity_o)
  );

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of resizing_stack_capacity_policy
// Drives push and pop operations with random gaps and output stalls, tracks
// the stack contents, capacity, resize count and peak capacity in a local
// model, and compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import rscp_pkg::*;

  localparam int Depth     = 1024;
  localparam int MinCap    = 10;
  localparam int CntW      = 11;
  localparam int IdleLimit = 4000;  // cycles without any transfer

  typedef struct {
    logic [31:0]     popped;
    status_e         status;
    logic [CntW-1:0] count;
    logic [CntW-1:0] cap;
    logic [EvtW-1:0] resizes;
    logic [CntW-1:0] peak;
  } stack_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  func_e               func_i;
  logic [31:0]         push_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [31:0]         popped_value_o;
  logic [StatW-1:0]    status_o;
  logic [CntW-1:0]     item_count_o;
  logic [CntW-1:0]     capacity_o;
  logic [EvtW-1:0]     resize_total_o;
  logic [CntW-1:0]     peak_capacity_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  cfg_idx_e            cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  resizing_stack_capacity_policy u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .popped_value_o (popped_value_o),
    .status_o       (status_o),
    .item_count_o   (item_count_o),
    .capacity_o     (capacity_o),
    .resize_total_o (resize_total_o),
    .peak_capacity_o(peak_capacity_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Stack model: contents, policy registers and bookkeeping
  // --------------------------------------------------------------------------
  logic [31:0]       stack_mem [Depth];
  int unsigned       stack_depth;
  int unsigned       cur_cap;
  longint unsigned   resize_cnt;
  int unsigned       max_cap;
  logic [CfgW-1:0]   full_thr;
  logic [CfgW-1:0]   empty_thr;
  logic [CfgW-1:0]   grow_ratio;
  logic [CfgW-1:0]   shrink_ratio;

  stack_result_t     pending_results [$];
  int                errors;
  int                idle_cycles;

  // Scale a capacity by an 8.8 fixed point ratio, truncate, clamp to depth.
  function automatic int unsigned scaled_cap(int unsigned c, logic [CfgW-1:0] r);
    longint unsigned p;
    p = (longint'(c) * longint'(r)) >> FracW;
    if (p > Depth) p = 64'(Depth);
    return int'(p);
  endfunction

  function automatic void bump_resizes();
    if (resize_cnt < 64'hFFFF_FFFF) resize_cnt++;
  endfunction

  // Apply one operation to the model and return the result it produces.
  function automatic stack_result_t apply_stack_op(func_e f, logic [31:0] v);
    stack_result_t r;
    r.popped = '0;
    r.status = ST_OK;
    if (f == FUNC_PUSH) begin
      // Grow first: fill fraction at or above the full threshold.
      if (longint'(stack_depth) * 256 >= longint'(full_thr) * longint'(cur_cap)) begin
        cur_cap = scaled_cap(cur_cap, grow_ratio);
        if (cur_cap > max_cap) max_cap = cur_cap;
        bump_resizes();
      end
      if (stack_depth >= Depth) begin
        r.status = ST_FULL;
      end else begin
        stack_mem[stack_depth] = v;
        stack_depth++;
      end
    end else begin
      // Shrink first: below the empty threshold and above the floor.
      if (longint'(stack_depth) * 256 < longint'(empty_thr) * longint'(cur_cap) &&
          cur_cap > MinCap) begin
        cur_cap = scaled_cap(cur_cap, shrink_ratio);
        bump_resizes();
      end
      if (stack_depth == 0) begin
        r.status = ST_EMPTY;
      end else begin
        stack_depth--;
        r.popped = stack_mem[stack_depth];
      end
    end
    r.count   = stack_depth[CntW-1:0];
    r.cap     = cur_cap[CntW-1:0];
    r.resizes = resize_cnt[EvtW-1:0];
    r.peak    = max_cap[CntW-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset and initial input values
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    func_i       = FUNC_PUSH;
    push_value_i = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_FULL_THR;
    cfg_data_i   = '0;
    stack_depth  = 0;
    cur_cap      = MinCap;
    resize_cnt   = 0;
    max_cap      = 0;
    full_thr     = FullThrRst;
    empty_thr    = EmptyThrRst;
    grow_ratio   = GrowRatioRst;
    shrink_ratio = ShrkRatioRst;
    errors       = 0;
  end

  // --------------------------------------------------------------------------
  // Result side: random stall with free-running stretches
  // --------------------------------------------------------------------------
  initial begin : stall_gen
    int hold;
    int pick;
    hold        = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall_i = 1'b0;
          hold        = $urandom_range(1, 20);
        end else if (pick < 95) begin
          out_stall_i = 1'b1;
          hold        = $urandom_range(0, 3);
        end else begin
          out_stall_i = 1'b1;
          hold        = $urandom_range(20, 60);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each result transfer with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i) begin
    stack_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected, actual count %0d",
                 $time, item_count_o);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("popped_value", 64'(exp_r.popped), 64'(popped_value_o));
        check_field("status", 64'(exp_r.status), 64'(status_o));
        check_field("item_count", 64'(exp_r.count), 64'(item_count_o));
        check_field("capacity", 64'(exp_r.cap), 64'(capacity_o));
        check_field("resize_total", 64'(exp_r.resizes), 64'(resize_total_o));
        check_field("peak_capacity", 64'(exp_r.peak), 64'(peak_capacity_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transfer happens for too long
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Send one operation after a random gap; hold valid and payload until the
  // transfer, then record the predicted result.
  task automatic send_op(func_e f, logic [31:0] v);
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (pick < 55)      gap = 0;
    else if (pick < 95) gap = $urandom_range(1, 3);
    else                gap = $urandom_range(10, 50);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    func_i       = f;
    push_value_i = v;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(apply_stack_op(f, v));
  endtask

  // Drop valid and wait until every predicted result has been checked.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_FULL_THR:   full_thr     = val;
      REG_EMPTY_THR:  empty_thr    = val;
      REG_GROW_RATIO: grow_ratio   = val;
      REG_SHRK_RATIO: shrink_ratio = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Reprogram the whole policy once the block has drained.
  task automatic set_policy(logic [CfgW-1:0] full, logic [CfgW-1:0] empty,
                            logic [CfgW-1:0] grow, logic [CfgW-1:0] shrink);
    wait_idle();
    write_reg(REG_FULL_THR, full);
    write_reg(REG_EMPTY_THR, empty);
    write_reg(REG_GROW_RATIO, grow);
    write_reg(REG_SHRK_RATIO, shrink);
  endtask

  // Issue n random operations, each a push with the given percentage.
  task automatic run_mix(int n, int push_pct);
    func_e f;
    repeat (n) begin
      f = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP;
      send_op(f, $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset policy: empty pop, extreme values, first growth and first shrink.
  task automatic test_basic_push_pop();
    send_op(FUNC_POP, 32'h0000_0000);
    send_op(FUNC_PUSH, 32'h7FFF_FFFF);
    send_op(FUNC_PUSH, 32'h8000_0000);
    send_op(FUNC_PUSH, 32'h0000_0000);
    send_op(FUNC_PUSH, 32'hFFFF_FFFF);
    send_op(FUNC_PUSH, 32'h5555_5555);
    send_op(FUNC_PUSH, 32'hAAAA_AAAA);
    // Push up to the initial capacity; the last of these pushes grows it.
    repeat (5) send_op(FUNC_PUSH, $urandom());
    // Pop everything: shrink fires once the fill drops low enough.
    repeat (12) send_op(FUNC_POP, $urandom());
    send_op(FUNC_POP, 32'hFFFF_FFFF);
  endtask

  // Reset policy rewritten; push until the memory is full, then push more
  // so the full status and the clamped capacity show up.
  task automatic test_fill_to_full();
    set_policy(FullThrRst, EmptyThrRst, GrowRatioRst, ShrkRatioRst);
    while (stack_depth < Depth) run_mix(1, 99);
    run_mix(40, 80);
  endtask

  // Random policies on a deep stack; ratios chosen so the capacity never
  // collapses to zero here.
  task automatic test_random_policies();
    repeat (6) begin
      set_policy(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(512, 65535)), 16'($urandom_range(26, 65535)));
      run_mix(40, $urandom_range(30, 70));
    end
  endtask

  // Shrink on every pop down to the floor while the count stays far above
  // the capacity, then mix pushes back in so growth clamps at the depth.
  task automatic test_shrink_to_floor();
    set_policy(16'd128, 16'hFFFF, 16'hFFFF, 16'd128);
    run_mix(60, 3);
    run_mix(30, 40);
  endtask

  // Zero ratios collapse the capacity to zero; from then on every push
  // counts a growth step and no pop shrinks.
  task automatic test_zero_capacity();
    set_policy(16'd0, 16'd0, 16'd0, 16'd0);
    run_mix(30, 50);
    set_policy(16'd0, 16'hFFFF, 16'd700, 16'd0);
    run_mix(30, 50);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_basic_push_pop();
    test_fill_to_full();
    test_random_policies();
    test_shrink_to_floor();
    test_zero_capacity();
    wait_idle();
    // Let any stray result show up before the verdict.
    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
